// ===== rtl/core/slsp_pkg.sv =====
// Shared types and constants for the serial link shift port.
// Used by the shift unit and the top level; the channel interfaces only match its widths.
// No dependencies.
package slsp_pkg;

  // request kinds
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_WRITE   = 2'd2;
  localparam logic [1:0] REQ_EXT_BIT = 2'd3;

  // bus map
  localparam logic [15:0] DATA_ADDR = 16'hFF01;
  localparam logic [15:0] CTRL_ADDR = 16'hFF02;

  // read values
  localparam logic [7:0] CTRL_FILL     = 8'h7E;
  localparam logic [7:0] UNMAPPED_READ = 8'hFF;

  // control register bit positions
  localparam int CTRL_EN_BIT  = 7;
  localparam int CTRL_INT_BIT = 0;

  // internal clock pacing, in ticks per bit (1 to 1024)
  localparam int BIT_PERIOD = 512;
  localparam int CD_W       = 10;
  localparam logic [CD_W-1:0] CD_RELOAD = CD_W'(BIT_PERIOD - 1);

  // bits per transfer
  localparam int BC_W = 3;
  localparam logic [BC_W-1:0] BC_LAST = '1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  wdata;
    logic        in_bit;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bit_out;
    logic       bit_valid;
    logic       irq;
  } rsp_t;

endpackage

// ===== rtl/core/slsp_req_if.sv =====
// Request channel of the serial link shift port: valid/ready plus request fields.
// Depends on nothing; widths match slsp_pkg::req_t.
interface slsp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] address;
  logic [7:0]  wdata;
  logic        in_bit;

  modport source (output valid, output req_type, output address, output wdata,
                  output in_bit, input ready);
  modport sink   (input valid, input req_type, input address, input wdata,
                  input in_bit, output ready);
endinterface

// ===== rtl/core/slsp_rsp_if.sv =====
// Result channel of the serial link shift port: valid/ready plus result fields.
// Depends on nothing; widths match slsp_pkg::rsp_t.
interface slsp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       bit_out;
  logic       bit_valid;
  logic       irq;

  modport source (output valid, output read_data, output bit_out, output bit_valid,
                  output irq, input ready);
  modport sink   (input valid, input read_data, input bit_out, input bit_valid,
                  input irq, output ready);
endinterface

// ===== rtl/core/serial_link_shift_port_core.sv =====
// Serial link shift port: a request goes from the input register to the result
// register. Throughput one request per cycle while results are taken; the input
// and result registers each hold one request; the state update lies between them.
// Synchronous active-high reset clears the shift register, control bits and
// counters and empties both pipeline registers; no request is taken during reset.
module serial_link_shift_port_core (
  input logic        clk,
  input logic        rst,
  slsp_req_if.sink   req,
  slsp_rsp_if.source rsp
);

  logic           in_valid;
  slsp_pkg::req_t in_reg;
  logic           rsp_valid;
  slsp_pkg::rsp_t rsp_reg;
  slsp_pkg::rsp_t result;
  logic           stall;
  logic           fire;

  // hold when the result register is full and not taken
  assign stall     = rsp_valid && !rsp.ready;
  assign fire      = in_valid && !stall;
  assign req.ready = !rst && (!in_valid || !stall);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_reg <= '{req_type: req.req_type, address: req.address,
                  wdata: req.wdata, in_bit: req.in_bit};
    end
  end

  slsp_shift_unit u_shift (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .cmd    (in_reg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!stall) begin
      rsp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_reg <= result;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_reg.read_data;
  assign rsp.bit_out   = rsp_reg.bit_out;
  assign rsp.bit_valid = rsp_reg.bit_valid;
  assign rsp.irq       = rsp_reg.irq;

endmodule

// ===== rtl/core/slsp_shift_unit.sv =====
// Port state (shift register, control bits, counters) and the per-request update.
// Depends on slsp_pkg.
module slsp_shift_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  slsp_pkg::req_t cmd,
  output slsp_pkg::rsp_t result
);

  logic [7:0]                  shift_data;
  logic                        transfer_enable;
  logic                        clock_internal;
  logic [slsp_pkg::BC_W-1:0]   bit_count;
  logic [slsp_pkg::CD_W-1:0]   tick_countdown;

  logic [7:0]                  shift_data_next;
  logic                        transfer_enable_next;
  logic                        clock_internal_next;
  logic [slsp_pkg::BC_W-1:0]   bit_count_next;
  logic [slsp_pkg::CD_W-1:0]   tick_countdown_next;

  logic                        do_shift;
  logic                        shift_in;
  logic [slsp_pkg::BC_W-1:0]   bc_eff;

  // decide the update for this request
  always_comb begin
    shift_data_next      = shift_data;
    transfer_enable_next = transfer_enable;
    clock_internal_next  = clock_internal;
    bit_count_next       = bit_count;
    tick_countdown_next  = tick_countdown;
    result               = '0;
    do_shift             = 1'b0;
    shift_in             = 1'b0;
    bc_eff               = bit_count;

    case (cmd.req_type)
      slsp_pkg::REQ_TICK: begin
        if (transfer_enable && clock_internal) begin
          if (tick_countdown == '0) begin
            do_shift = 1'b1;
            shift_in = cmd.in_bit;
          end else begin
            tick_countdown_next = tick_countdown - 1'b1;
          end
        end
      end
      slsp_pkg::REQ_READ: begin
        if (cmd.address == slsp_pkg::DATA_ADDR) begin
          result.read_data = shift_data;
        end else if (cmd.address == slsp_pkg::CTRL_ADDR) begin
          result.read_data = slsp_pkg::CTRL_FILL;
          result.read_data[slsp_pkg::CTRL_EN_BIT]  = transfer_enable;
          result.read_data[slsp_pkg::CTRL_INT_BIT] = clock_internal;
        end else begin
          result.read_data = slsp_pkg::UNMAPPED_READ;
        end
      end
      slsp_pkg::REQ_WRITE: begin
        if (cmd.address == slsp_pkg::DATA_ADDR) begin
          shift_data_next = cmd.wdata;
        end else if (cmd.address == slsp_pkg::CTRL_ADDR) begin
          transfer_enable_next = cmd.wdata[slsp_pkg::CTRL_EN_BIT];
          clock_internal_next  = cmd.wdata[slsp_pkg::CTRL_INT_BIT];
          // restart counters when enabling
          if (cmd.wdata[slsp_pkg::CTRL_EN_BIT]) begin
            tick_countdown_next = '0;
            bit_count_next      = '0;
          end
        end
      end
      slsp_pkg::REQ_EXT_BIT: begin
        // start a transfer if none is running
        if (!transfer_enable) begin
          bc_eff = '0;
        end
        transfer_enable_next = 1'b1;
        do_shift             = 1'b1;
        shift_in             = cmd.wdata[0];
      end
      default: begin
      end
    endcase

    // shift one bit: MSB out, partner bit in
    if (do_shift) begin
      result.bit_valid = 1'b1;
      result.bit_out   = shift_data[7];
      shift_data_next  = {shift_data[6:0], shift_in};
      if (bc_eff == slsp_pkg::BC_LAST) begin
        bit_count_next       = '0;
        transfer_enable_next = 1'b0;
        result.irq           = 1'b1;
      end else begin
        bit_count_next = bc_eff + 1'b1;
        if (cmd.req_type == slsp_pkg::REQ_TICK) begin
          tick_countdown_next = slsp_pkg::CD_RELOAD;
        end
      end
    end
  end

  // commit state on each request that leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_data      <= '0;
      transfer_enable <= 1'b0;
      clock_internal  <= 1'b0;
      bit_count       <= '0;
      tick_countdown  <= '0;
    end else if (fire) begin
      shift_data      <= shift_data_next;
      transfer_enable <= transfer_enable_next;
      clock_internal  <= clock_internal_next;
      bit_count       <= bit_count_next;
      tick_countdown  <= tick_countdown_next;
    end
  end

endmodule

// ===== rtl/core/slsp_checker.sv =====
// Port-level checks for the serial link shift port, bound to the top level.
// Depends on serial_link_shift_port_core port names.
module slsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] read_data,
  input logic       bit_out,
  input logic       bit_valid,
  input logic       irq
);

  // a pending result stays offered until taken
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before taken");

  // a sent bit only comes with a shift
  a_bit_needs_shift: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bit_out |-> bit_valid)
    else $error("bit_out without shift");

  // transfer done only on a shift
  a_irq_needs_shift: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && irq |-> bit_valid)
    else $error("irq without shift");

  // a shift never carries read data
  a_shift_no_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bit_valid |-> read_data == 8'h00)
    else $error("read data on a shift result");

endmodule

bind serial_link_shift_port_core slsp_checker u_slsp_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .read_data (rsp.read_data),
  .bit_out   (rsp.bit_out),
  .bit_valid (rsp.bit_valid),
  .irq       (rsp.irq)
);
